>>> hdl/scl_pkg.sv
package scl_pkg;

	localparam int SCORE_W      = 17;
	localparam int RANK_W       = 17;
	localparam int ENTRY_W      = SCORE_W + RANK_W;
	localparam int CFG_W        = 11;
	localparam int IDX_W        = 10;
	localparam int SLOPE_W      = 32;
	localparam int DEF_MAX_ENTRIES = 1024;

	// Divider operand widths: the value numerator reaches about 2^37,
	// the doubled run stays below 2^19.
	localparam int DIV_NUM_W    = 38;
	localparam int DIV_DEN_W    = 20;

	localparam logic [SCORE_W-1:0] ONE_FX  = 17'd65536;
	localparam logic [SCORE_W-1:0] HALF_FX = 17'd32768;
	localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'hFFFF_FFFF;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

endpackage

>>> hdl/scl_ram.sv
module scl_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/scl_div.sv
module scl_div #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic             fits;

	// One restoring step per cycle: the numerator shifts out of the top of
	// quo_q while quotient bits shift in at the bottom.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		fits    = ~diff[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> hdl/smoothed_cdf_lookup.sv
// Smoothed CDF lookup over a score-sorted table held in one single-port-read
// RAM. A write transaction stores one entry and moves to S_DONE, which
// raises its acknowledge and frees the input once the output register is
// free. A query binary-searches the table, each probe of the RAM passing
// S_SADDR and S_SCMP (at most ceil(log2(n+1)) probes for n entries in
// use), then fetches the neighbors through S_FA to S_FD, forms the rise and
// run and multiplies once. The slope and the interpolated value each take
// at most one pass of a shared radix-2 divider: 38 steps plus the start and
// the wait. Edge cases that need no division skip the divider. The block
// takes one transaction at a time; a finished result waits in the output
// register while the next transaction is accepted.
module smoothed_cdf_lookup #(
	parameter int MAX_ENTRIES = scl_pkg::DEF_MAX_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [scl_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [scl_pkg::IDX_W-1:0]     entry_index,
	input  logic [scl_pkg::SCORE_W-1:0]   entry_score,
	input  logic [scl_pkg::RANK_W-1:0]    entry_rank,
	input  logic [scl_pkg::SCORE_W-1:0]   probe_score,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_query_result,
	output logic [scl_pkg::SCORE_W-1:0]   cdf_value,
	output logic [scl_pkg::SLOPE_W-1:0]   cdf_slope,
	output logic                          slope_saturated
);

	import scl_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SADDR, S_SCMP, S_FA, S_FB, S_FC, S_FD, S_CALC,
		S_MUL, S_SDIV, S_SWAIT, S_VDIV, S_VWAIT, S_DONE
	} state_t;

	state_t state_q;

	logic [NW-1:0]      n_q, lo_q, hi_q;
	logic [SCORE_W-1:0] probe_q, last_score_q, sa_q, sb_q;
	logic [RANK_W-1:0]  ra_q, rb_q, rp_q;
	logic               b_last_q, eq_q, neg_q;
	logic signed [19:0] rise_q, run_q, dd_q;
	logic signed [39:0] prod_q;
	logic [SCORE_W-1:0] val_q;
	logic [SLOPE_W-1:0] slope_q;
	logic               sat_q, isq_q;

	logic               out_valid_q, is_query_q, sat_out_q;
	logic [SCORE_W-1:0] cdf_value_q;
	logic [SLOPE_W-1:0] cdf_slope_q;

	logic               in_acc;
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [SCORE_W-1:0] rd_score;
	logic [RANK_W-1:0]  rd_rank;
	logic [NW:0]        mid_sum;
	logic [NW-1:0]      mid;
	logic [AW-1:0]      a_idx;

	logic               div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den, div_rem;

	logic [17:0]        mid2, p2;
	logic signed [19:0] sa_x, sb_x, ra_x, rb_x, rp_x, d_x;
	logic signed [19:0] rise_c, run_c;
	logic signed [40:0] vnum;
	logic [DIV_NUM_W-1:0] vnum_mag;
	logic signed [39:0] q_mag, q_val, vsum;
	logic [SCORE_W-1:0] ra_clamped, v_clamped;
	logic [CFG_W-1:0]   cfg_n;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign ram_we   = in_acc && (func == FUNC_WRITE) &&
		(32'(entry_index) < 32'(MAX_ENTRIES));

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[NW:1];
	assign a_idx   = AW'(lo_q - 1'b1);
	assign rd_score = ram_rdata[ENTRY_W-1:RANK_W];
	assign rd_rank  = ram_rdata[RANK_W-1:0];

	always_comb begin
		unique case (state_q)
			S_FA:    ram_raddr = a_idx;
			S_FB:    ram_raddr = AW'(lo_q);
			S_FC:    ram_raddr = a_idx - 1'b1;
			default: ram_raddr = AW'(mid);
		endcase
	end

	scl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(entry_index)),
		.wdata ({entry_score, entry_rank}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Doubled midpoints keep the interpolation exact.
	always_comb begin
		mid2 = {1'b0, sa_q} + {1'b0, sb_q};
		p2   = {probe_q, 1'b0};
		sa_x = $signed({3'b000, sa_q});
		sb_x = $signed({3'b000, sb_q});
		ra_x = $signed({3'b000, ra_q});
		rb_x = $signed({3'b000, rb_q});
		rp_x = $signed({3'b000, rp_q});
		d_x  = $signed({2'b00, p2}) - $signed({2'b00, mid2});
		if (p2 == mid2) begin
			rise_c = rb_x - rp_x;
			run_c  = (sb_x - sa_x) <<< 1;
		end else if (p2 > mid2) begin
			rise_c = (b_last_q ? (rb_x <<< 1) : (ra_x + rb_x)) - (ra_x <<< 1);
			run_c  = sb_x - sa_x;
		end else begin
			// Below the first step the curve starts from zero.
			rise_c = (ra_x <<< 1) - ((a_idx == '0) ? 20'sd0 : (rp_x + ra_x));
			run_c  = sb_x - sa_x;
		end
	end

	always_comb begin
		vnum     = 41'(prod_q) + 41'(run_q);
		vnum_mag = vnum[40] ? DIV_NUM_W'(-vnum) : DIV_NUM_W'(vnum);
		q_mag    = $signed({2'b00, div_quo}) +
			$signed({39'b0, (neg_q && (div_rem != '0))});
		q_val    = neg_q ? -q_mag : q_mag;
		vsum     = q_val + $signed({23'b0, ra_q});
		if (vsum < 0) begin
			v_clamped = '0;
		end else if (vsum > 40'sd65536) begin
			v_clamped = ONE_FX;
		end else begin
			v_clamped = vsum[SCORE_W-1:0];
		end
		ra_clamped = (ra_q > ONE_FX) ? ONE_FX : ra_q;
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (state_q == S_SDIV) begin
			div_start = 1'b1;
			div_num   = DIV_NUM_W'(rise_q[17:0]) << 16;
			div_den   = run_q[DIV_DEN_W-1:0];
		end else if (state_q == S_VDIV) begin
			div_start = 1'b1;
			div_num   = vnum_mag;
			div_den   = DIV_DEN_W'(run_q <<< 1);
		end
	end

	scl_div #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// A count of zero acts as one, and a count above the table as its size.
	assign cfg_n = (cfg_wr_data == '0) ? CFG_W'(1) : cfg_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(1);
		end else if (cfg_wr_en) begin
			if (32'(cfg_n) > 32'(MAX_ENTRIES)) begin
				n_q <= NW'(MAX_ENTRIES);
			end else begin
				n_q <= NW'(cfg_n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						probe_q <= probe_score;
						val_q   <= '0;
						slope_q <= '0;
						sat_q   <= 1'b0;
						lo_q    <= '0;
						hi_q    <= n_q;
						if (func == FUNC_QUERY) begin
							isq_q   <= 1'b1;
							state_q <= S_SADDR;
						end else begin
							isq_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_SADDR: begin
					if (lo_q < hi_q) begin
						state_q <= S_SCMP;
					end else if (n_q == NW'(1)) begin
						if (lo_q == '0) begin
							val_q <= '0;
						end else if (last_score_q == probe_q) begin
							val_q <= HALF_FX;
						end else begin
							val_q <= ONE_FX;
						end
						state_q <= S_DONE;
					end else if (lo_q == n_q) begin
						val_q   <= ONE_FX;
						state_q <= S_DONE;
					end else if (lo_q == '0) begin
						state_q <= S_DONE;
					end else begin
						b_last_q <= (lo_q == n_q - 1'b1);
						state_q  <= S_FA;
					end
				end
				S_SCMP: begin
					last_score_q <= rd_score;
					if (rd_score > probe_q) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid + 1'b1;
					end
					state_q <= S_SADDR;
				end
				S_FA: begin
					state_q <= S_FB;
				end
				S_FB: begin
					sa_q    <= rd_score;
					ra_q    <= rd_rank;
					state_q <= S_FC;
				end
				S_FC: begin
					sb_q    <= rd_score;
					rb_q    <= rd_rank;
					state_q <= S_FD;
				end
				S_FD: begin
					rp_q    <= (a_idx == '0) ? '0 : rd_rank;
					state_q <= S_CALC;
				end
				S_CALC: begin
					rise_q  <= rise_c;
					run_q   <= run_c;
					dd_q    <= d_x;
					eq_q    <= (p2 == mid2);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= rise_q * dd_q;
					if (run_q <= 0) begin
						slope_q <= SLOPE_MAX;
						sat_q   <= 1'b1;
						val_q   <= ra_clamped;
						state_q <= S_DONE;
					end else if (rise_q < 0) begin
						sat_q <= 1'b1;
						if (eq_q) begin
							val_q   <= ra_clamped;
							state_q <= S_DONE;
						end else begin
							state_q <= S_VDIV;
						end
					end else begin
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (div_done) begin
						if (div_quo[DIV_NUM_W-1:SLOPE_W] != '0) begin
							slope_q <= SLOPE_MAX;
							sat_q   <= 1'b1;
						end else begin
							slope_q <= div_quo[SLOPE_W-1:0];
						end
						if (eq_q) begin
							val_q   <= ra_clamped;
							state_q <= S_DONE;
						end else begin
							state_q <= S_VDIV;
						end
					end
				end
				S_VDIV: begin
					neg_q   <= vnum[40];
					state_q <= S_VWAIT;
				end
				S_VWAIT: begin
					if (div_done) begin
						val_q   <= v_clamped;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						is_query_q  <= isq_q;
						cdf_value_q <= val_q;
						cdf_slope_q <= slope_q;
						sat_out_q   <= sat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign is_query_result = is_query_q;
	assign cdf_value       = cdf_value_q;
	assign cdf_slope       = cdf_slope_q;
	assign slope_saturated = sat_out_q;

`ifndef SYNTHESIS
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_query_result |->
			cdf_value == '0 && cdf_slope == '0 && !slope_saturated)
		else $error("write acknowledge carries nonzero result");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cdf_value <= ONE_FX)
		else $error("cdf value above one");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCMP |-> lo_q < hi_q && hi_q <= n_q)
		else $error("search bounds out of order");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a transaction while busy");
`endif

endmodule
